// ===== src/assert_macros.svh =====
// assertion macros used by the noise texture rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define VNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define VNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/vnt_pkg.sv =====
// shared types, constants and codes of the value noise texture block
package vnt_pkg;

  localparam int unsigned MAX_OCTAVES = 8;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned OCT_W       = 4;
  localparam int unsigned LAT_W       = 18;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned LERP_W      = 22;
  localparam int unsigned PROD_W      = 2 * LERP_W;
  localparam int unsigned TOT_W       = 26;
  localparam int unsigned SX_W        = 49;
  localparam int unsigned AMP_W       = FRAC_BITS + 1;
  localparam int unsigned HASH_DROP   = 30 - FRAC_BITS;

  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_M1    = 32'd15731;
  localparam logic [31:0] HASH_A1    = 32'd789221;
  localparam logic [31:0] HASH_A2    = 32'd1376312589;

  // configuration register indexes
  localparam logic [2:0] CFG_OCTAVES = 3'd0;
  localparam logic [2:0] CFG_PERSIST = 3'd1;
  localparam logic [2:0] CFG_SCALE   = 3'd2;
  localparam logic [2:0] CFG_COLOR1  = 3'd3;
  localparam logic [2:0] CFG_COLOR2  = 3'd4;

  // interpolation and accumulation steps
  localparam logic [1:0] STEP_ROW0 = 2'd0;
  localparam logic [1:0] STEP_ROW1 = 2'd1;
  localparam logic [1:0] STEP_COL  = 2'd2;
  localparam logic [1:0] STEP_ACC  = 2'd3;

  // color channels
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
  } in_t;

  typedef struct packed {
    logic signed [19:0] noise_coeff;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       hash_issue;
    logic [3:0] sel;
    logic       smooth_en;
    logic       mul_en;
    logic       add_en;
    logic       oct_next;
    logic       color_en;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_busy;
    logic zero_oct;
    logic last_oct;
  } dp_sts_t;

endpackage

// ===== src/value_noise_texture_2d.sv =====
// top level of the two-dimensional value noise texture block
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  input    | in_valid_i / in_ready_o | in_data_i  (u_coord, v_coord)
//  output   | out_valid_o/out_ready_i | out_data_o (noise_coeff, rgb)
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// per octave the 4-stage hash unit is issued 16 times and drained, then the grid
// is smoothed and the row, column and accumulate lerp steps run
// reset clears the sequencer and loads the register defaults; no clearing pass
// a new transaction is taken while a finished result still waits; a result that
// is not taken stalls the next one in its final cycle
module value_noise_texture_2d (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vnt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vnt_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i
);
  import vnt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  vnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vnt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

// ===== src/vnt_hash.sv =====
// four stage pipelined integer lattice hash
module vnt_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            issue_i,
  input  logic [31:0]                     gx_i,
  input  logic [31:0]                     gy_i,
  input  logic [3:0]                      tag_i,
  output logic                            valid_o,
  output logic [3:0]                      tag_o,
  output logic signed [vnt_pkg::LAT_W-1:0] value_o,
  output logic                            busy_o
);
  import vnt_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [3:0]  tag1_q, tag2_q, tag3_q, tag4_q;
  logic [31:0] n0, n1_d, n1_q, n2_q, n3_q, p2_q, q3_q, r4_q;

  assign n0   = gx_i + gy_i * HASH_Y_MUL;
  assign n1_d = (n0 << HASH_SHIFT) ^ n0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= n1_d;
    tag1_q <= tag_i;
    p2_q   <= n1_q * n1_q;
    n2_q   <= n1_q;
    tag2_q <= tag1_q;
    q3_q   <= p2_q * HASH_M1 + HASH_A1;
    n3_q   <= n2_q;
    tag3_q <= tag2_q;
    r4_q   <= n3_q * q3_q + HASH_A2;
    tag4_q <= tag3_q;
  end

  // one minus the top bits of the masked hash
  assign value_o = $signed(LAT_W'(1 << FRAC_BITS)) - $signed({1'b0, r4_q[30:HASH_DROP]});
  assign valid_o = v4_q;
  assign tag_o   = tag4_q;
  assign busy_o  = v1_q | v2_q | v3_q | v4_q;

endmodule

// ===== src/vnt_dp.sv =====
// datapath: config registers, lattice grid, smoothing, interpolation and color mix
module vnt_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [23:0]      cfg_data_i,
  input  vnt_pkg::in_t     in_data_i,
  input  vnt_pkg::dp_cmd_t cmd_i,
  output vnt_pkg::dp_sts_t sts_o,
  output vnt_pkg::out_t    out_data_o
);
  import vnt_pkg::*;

  logic [OCT_W-1:0] octaves_q, oct_q, lim_q, lim_d;
  logic [15:0]      pers_q;
  logic [9:0]       scale_q;
  logic [23:0]      col1_q, col2_q;

  logic signed [42:0]     bx, by;
  logic signed [SX_W-1:0] sx_q, sy_q;
  logic                   fx, fy;
  logic [31:0]            ix, iy, gx, gy;
  logic signed [16:0]     tx, ty;

  logic                    h_valid, h_busy;
  logic [3:0]              h_tag;
  logic signed [LAT_W-1:0] h_value;
  logic signed [LAT_W-1:0] grid_q [16];
  logic signed [LAT_W-1:0] sm_q [4];

  logic [1:0]              r0, r1, r2, c0, c1, c2;
  logic signed [SUM_W-1:0] corners, sides, center, smsum, smbias;

  logic signed [LERP_W-1:0] ma, mb, op_x, op_y, l0_q, l1_q, v_q;
  logic signed [PROD_W-1:0] prod_q, pbias;
  logic signed [27:0]       quo;
  logic [AMP_W-1:0]         amp_q;
  logic [AMP_W+15:0]        amp_prod;
  logic signed [TOT_W-1:0]  total_q;

  logic signed [19:0] coeff;
  logic [7:0]         c1v, c2v;
  logic signed [29:0] mix, mixb;
  logic signed [13:0] mq;
  logic [7:0]         chan;
  logic [7:0]         red_q, green_q, blue_q;
  out_t               out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octaves_q <= 4'd4;
      pers_q    <= 16'd32768;
      scale_q   <= 10'd100;
      col1_q    <= 24'h6633CC;
      col2_q    <= 24'h1AB34D;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OCTAVES: octaves_q <= cfg_data_i[OCT_W-1:0];
        CFG_PERSIST: pers_q    <= cfg_data_i[15:0];
        CFG_SCALE:   scale_q   <= cfg_data_i[9:0];
        CFG_COLOR1:  col1_q    <= cfg_data_i;
        CFG_COLOR2:  col2_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lim_d = (octaves_q > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : octaves_q;

  // scaled coordinates, doubled after each octave
  assign bx = in_data_i.u_coord * $signed({1'b0, scale_q});
  assign by = in_data_i.v_coord * $signed({1'b0, scale_q});

  // truncation toward zero: negative with nonzero fraction rounds the index up
  assign fx = sx_q[SX_W-1] & (|sx_q[FRAC_BITS-1:0]);
  assign fy = sy_q[SX_W-1] & (|sy_q[FRAC_BITS-1:0]);
  assign ix = sx_q[FRAC_BITS+31:FRAC_BITS] + {31'd0, fx};
  assign iy = sy_q[FRAC_BITS+31:FRAC_BITS] + {31'd0, fy};
  assign tx = {fx, sx_q[FRAC_BITS-1:0]};
  assign ty = {fy, sy_q[FRAC_BITS-1:0]};
  assign gx = ix + {30'd0, cmd_i.sel[1:0]} - 32'd1;
  assign gy = iy + {30'd0, cmd_i.sel[3:2]} - 32'd1;

  vnt_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (cmd_i.hash_issue),
    .gx_i    (gx),
    .gy_i    (gy),
    .tag_i   (cmd_i.sel),
    .valid_o (h_valid),
    .tag_o   (h_tag),
    .value_o (h_value),
    .busy_o  (h_busy)
  );

  always_ff @(posedge clk_i) begin
    if (h_valid) begin
      grid_q[h_tag] <= h_value;
    end
  end

  // 3x3 smoothing around grid point (1+cx, 1+cy)
  assign r0 = {1'b0, cmd_i.sel[1]};
  assign r1 = r0 + 2'd1;
  assign r2 = r0 + 2'd2;
  assign c0 = {1'b0, cmd_i.sel[0]};
  assign c1 = c0 + 2'd1;
  assign c2 = c0 + 2'd2;

  assign corners = SUM_W'(grid_q[{r0, c0}]) + SUM_W'(grid_q[{r0, c2}])
                 + SUM_W'(grid_q[{r2, c0}]) + SUM_W'(grid_q[{r2, c2}]);
  assign sides   = SUM_W'(grid_q[{r1, c0}]) + SUM_W'(grid_q[{r1, c2}])
                 + SUM_W'(grid_q[{r0, c1}]) + SUM_W'(grid_q[{r2, c1}]);
  assign center  = SUM_W'(grid_q[{r1, c1}]);
  assign smsum   = corners + (sides <<< 1) + (center <<< 2);
  assign smbias  = smsum + (smsum[SUM_W-1] ? SUM_W'(15) : SUM_W'(0));

  always_ff @(posedge clk_i) begin
    if (cmd_i.smooth_en) begin
      sm_q[cmd_i.sel[1:0]] <= smbias[SUM_W-1:4];
    end
  end

  // lerp and accumulate operands
  always_comb begin
    ma   = LERP_W'(sm_q[0]);
    mb   = LERP_W'(sm_q[1]);
    op_x = LERP_W'(tx);
    case (cmd_i.sel[1:0])
      STEP_ROW0: begin
        ma   = LERP_W'(sm_q[0]);
        mb   = LERP_W'(sm_q[1]);
        op_x = LERP_W'(tx);
      end
      STEP_ROW1: begin
        ma   = LERP_W'(sm_q[2]);
        mb   = LERP_W'(sm_q[3]);
        op_x = LERP_W'(tx);
      end
      STEP_COL: begin
        ma   = l0_q;
        mb   = l1_q;
        op_x = LERP_W'(ty);
      end
      STEP_ACC: begin
        ma   = v_q;
        mb   = v_q;
        op_x = $signed({{(LERP_W-AMP_W){1'b0}}, amp_q});
      end
      default: ;
    endcase
    op_y = (cmd_i.sel[1:0] == STEP_ACC) ? v_q : (mb - ma);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= op_x * op_y;
    end
  end

  assign pbias = prod_q + (prod_q[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign quo   = pbias[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      case (cmd_i.sel[1:0])
        STEP_ROW0: l0_q <= ma + quo[LERP_W-1:0];
        STEP_ROW1: l1_q <= ma + quo[LERP_W-1:0];
        STEP_COL:  v_q  <= ma + quo[LERP_W-1:0];
        default:   v_q  <= v_q;
      endcase
    end
  end

  assign amp_prod = amp_q * pers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q <= '0;
      lim_q <= '0;
    end else if (cmd_i.load) begin
      oct_q <= '0;
      lim_q <= lim_d;
    end else if (cmd_i.oct_next) begin
      oct_q <= oct_q + OCT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q    <= SX_W'(bx);
      sy_q    <= SX_W'(by);
      total_q <= '0;
      amp_q   <= AMP_W'(1 << FRAC_BITS);
    end else begin
      if (cmd_i.oct_next) begin
        sx_q  <= sx_q <<< 1;
        sy_q  <= sy_q <<< 1;
        amp_q <= amp_prod[AMP_W+15:16];
      end
      if (cmd_i.add_en && (cmd_i.sel[1:0] == STEP_ACC)) begin
        total_q <= total_q + quo[TOT_W-1:0];
      end
    end
  end

  // saturated coefficient
  always_comb begin
    if (total_q > TOT_W'(524287)) begin
      coeff = 20'sd524287;
    end else if (total_q < -TOT_W'(524288)) begin
      coeff = -20'sd524288;
    end else begin
      coeff = total_q[19:0];
    end
  end

  // one channel per cycle: coeff * (c1 - c2) + c2 * one
  always_comb begin
    case (cmd_i.sel[1:0])
      CH_RED: begin
        c1v = col1_q[23:16];
        c2v = col2_q[23:16];
      end
      CH_GREEN: begin
        c1v = col1_q[15:8];
        c2v = col2_q[15:8];
      end
      default: begin
        c1v = col1_q[7:0];
        c2v = col2_q[7:0];
      end
    endcase
  end

  assign mix  = 30'(coeff) * 30'($signed({1'b0, c1v}) - $signed({1'b0, c2v}))
              + $signed({6'd0, c2v, 16'd0});
  assign mixb = mix + (mix[29] ? 30'sd65535 : 30'sd0);
  assign mq   = mixb[29:16];
  assign chan = mq[13] ? 8'd0 : ((mq > 14'sd255) ? 8'd255 : mq[7:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.color_en) begin
      case (cmd_i.sel[1:0])
        CH_RED:   red_q   <= chan;
        CH_GREEN: green_q <= chan;
        default:  blue_q  <= chan;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.noise_coeff <= coeff;
      out_q.red         <= red_q;
      out_q.green       <= green_q;
      out_q.blue        <= blue_q;
    end
  end

  assign sts_o.hash_busy = h_busy;
  assign sts_o.zero_oct  = (octaves_q == '0);
  assign sts_o.last_oct  = ((oct_q + OCT_W'(1)) == lim_q);
  assign out_data_o      = out_q;

endmodule

// ===== src/vnt_ctrl.sv =====
// controller: sequences hashing, smoothing and interpolation per octave, then color
`include "assert_macros.svh"

module vnt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  vnt_pkg::dp_sts_t sts_i,
  output vnt_pkg::dp_cmd_t cmd_o
);
  import vnt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HASH   = 3'd1;
  localparam logic [2:0] S_SMOOTH = 3'd2;
  localparam logic [2:0] S_LERP   = 3'd3;
  localparam logic [2:0] S_COLOR  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.zero_oct ? S_COLOR : S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.sel = cnt_q[3:0];
        if (!cnt_q[4]) begin
          cmd_o.hash_issue = 1'b1;
          cnt_d            = cnt_q + 5'd1;
        end else if (!sts_i.hash_busy) begin
          cnt_d   = '0;
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd_o.smooth_en = 1'b1;
        cmd_o.sel       = {2'b00, cnt_q[1:0]};
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = S_LERP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_LERP: begin
        // even cycle multiplies, odd cycle adds
        cmd_o.sel    = {2'b00, cnt_q[2:1]};
        cmd_o.mul_en = !cnt_q[0];
        cmd_o.add_en = cnt_q[0];
        if (cnt_q[2:0] == 3'd7) begin
          cmd_o.oct_next = 1'b1;
          cnt_d          = '0;
          state_d        = sts_i.last_oct ? S_COLOR : S_HASH;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_COLOR: begin
        cmd_o.color_en = 1'b1;
        cmd_o.sel      = {2'b00, cnt_q[1:0]};
        if (cnt_q[1:0] == CH_BLUE) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `VNT_ASSERT_IMP(a_smooth_after_hash, $rose(state_q == S_SMOOTH), $past(state_q) == S_HASH, "smoothing entered without hashing")
  `VNT_ASSERT_IMP(a_grid_settled, state_q == S_SMOOTH, !sts_i.hash_busy, "hash pipeline busy during smoothing")
  `VNT_ASSERT_IMP(a_last_octave, (state_q == S_COLOR) && ($past(state_q) == S_LERP), $past(sts_i.last_oct), "color mix before last octave")

endmodule

// ===== sim/tb.sv =====
// testbench for the value noise texture block: directed and random items checked
// against a behavioral predictor
`timescale 1ns / 100ps

module tb;
  import vnt_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         DRAIN_CYCLES = 300;
  localparam longint     ONE = 64'sd1 <<< FRAC_BITS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // shadow copy of the configuration registers
  logic [3:0]  oct_count;
  logic [15:0] persist;
  logic [9:0]  scale;
  logic [23:0] color_a;
  logic [23:0] color_b;

  out_t pixel_q[$];
  int   mismatches = 0;
  bit   idle_en = 1'b1;
  int   quiet_cycles = 0;

  value_noise_texture_2d uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint lattice(bit [31:0] x, bit [31:0] y);
    bit [31:0] n;
    bit [31:0] m;
    n = x + y * 32'd57;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return ONE - longint'(m >> (30 - FRAC_BITS));
  endfunction

  function automatic longint smooth(bit [31:0] x, bit [31:0] y);
    longint corners;
    longint sides;
    corners = lattice(x - 1, y - 1) + lattice(x + 1, y - 1)
            + lattice(x - 1, y + 1) + lattice(x + 1, y + 1);
    sides = lattice(x - 1, y) + lattice(x + 1, y) + lattice(x, y - 1) + lattice(x, y + 1);
    return (corners + 2 * sides + 4 * lattice(x, y)) / 16;
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + (t * (b - a)) / ONE;
  endfunction

  function automatic longint octave_value(longint sx, longint sy);
    longint    ix;
    longint    iy;
    longint    tx;
    longint    ty;
    bit [31:0] x;
    bit [31:0] y;
    ix = sx / ONE;
    iy = sy / ONE;
    tx = sx - ix * ONE;
    ty = sy - iy * ONE;
    x = ix[31:0];
    y = iy[31:0];
    return lerp(ty, lerp(tx, smooth(x, y), smooth(x + 1, y)),
                lerp(tx, smooth(x, y + 1), smooth(x + 1, y + 1)));
  endfunction

  function automatic logic [7:0] channel(longint coeff, logic [7:0] c1, logic [7:0] c2);
    longint v;
    v = (coeff * longint'(c1) + (ONE - coeff) * longint'(c2)) / ONE;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic out_t texel(in_t d);
    longint bx;
    longint by;
    longint amp;
    longint total;
    int     cnt;
    out_t   r;
    bx = longint'(d.u_coord) * longint'(scale);
    by = longint'(d.v_coord) * longint'(scale);
    cnt = (oct_count > MAX_OCTAVES) ? MAX_OCTAVES : oct_count;
    amp = ONE;
    total = 0;
    for (int i = 0; i < cnt; i++) begin
      total += (octave_value(bx <<< i, by <<< i) * amp) / ONE;
      amp = (amp * longint'(persist)) >> 16;
    end
    if (total > 524287) total = 524287;
    if (total < -524288) total = -524288;
    r.noise_coeff = total[19:0];
    r.red = channel(total, color_a[23:16], color_b[23:16]);
    r.green = channel(total, color_a[15:8], color_b[15:8]);
    r.blue = channel(total, color_a[7:0], color_b[7:0]);
    return r;
  endfunction

  task automatic send_item(logic [31:0] u, logic [31:0] v);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.u_coord <= u;
    in_data_i.v_coord <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_q.push_back(texel(in_data_i));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    drain();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OCTAVES: oct_count = data[3:0];
      CFG_PERSIST: persist = data[15:0];
      CFG_SCALE:   scale = data[9:0];
      CFG_COLOR1:  color_a = data;
      CFG_COLOR2:  color_b = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_extremes();
    send_item(32'h0, 32'h0);
    send_item(32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000);
    send_item(32'h7fffffff, 32'h80000000);
    send_item(32'hffffffff, 32'h00000001);
    send_item(32'h00018000, 32'hfffe8000);
    send_item(32'h0000ffff, 32'hffff0001);
    write_reg(CFG_SCALE, 24'd1023);
    write_reg(CFG_OCTAVES, 24'd8);
    send_item(32'h7fffffff, 32'h80000000);
    send_item(32'h80000000, 32'h12345678);
  endtask

  task automatic test_octaves();
    write_reg(CFG_OCTAVES, 24'd0);
    send_item(32'h00012345, 32'h00054321);
    write_reg(CFG_OCTAVES, 24'd15);
    send_item(32'h00012345, 32'h00054321);
    write_reg(CFG_OCTAVES, 24'd9);
    write_reg(CFG_PERSIST, 24'd65535);
    write_reg(CFG_COLOR1, 24'hffffff);
    write_reg(CFG_COLOR2, 24'h000000);
    send_item(32'hfff00000, 32'h00100000);
    send_item(32'h7fff0000, 32'h00a00000);
    write_reg(CFG_PERSIST, 24'd0);
    write_reg(CFG_COLOR1, 24'h000000);
    write_reg(CFG_COLOR2, 24'hffffff);
    send_item(32'h00031234, 32'hfff43210);
    write_reg(CFG_SCALE, 24'd0);
    send_item(32'h55555555, 32'haaaaaaaa);
    write_reg(CFG_UNUSED, 24'hffffff);
    write_reg(CFG_UNUSED - 3'd1, 24'h123456);
    send_item(32'haaaaaaaa, 32'h55555555);
  endtask

  task automatic test_random();
    logic [31:0] u;
    logic [31:0] v;
    for (int phase = 0; phase < 10; phase++) begin
      write_reg(CFG_OCTAVES, (phase % 3 == 0) ? 24'($urandom_range(1, 3))
                                              : 24'($urandom_range(0, 15)));
      write_reg(CFG_PERSIST, 24'($urandom_range(0, 65535)));
      write_reg(CFG_SCALE, (phase == 4) ? 24'd1023 : 24'($urandom_range(0, 1023)));
      write_reg(CFG_COLOR1, 24'($urandom));
      write_reg(CFG_COLOR2, 24'($urandom));
      idle_en = (phase != 5);
      for (int k = 0; k < 48; k++) begin
        if ($urandom_range(0, 1)) begin
          u = $urandom;
          v = $urandom;
        end else begin
          u = 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
          v = 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
        end
        send_item(u, v);
      end
    end
    idle_en = 1'b1;
  endtask

  // result ready with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !(idle_en && $urandom_range(0, 99) < 20);
  end

  // compare each result transaction with the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        out_t exp_px;
        exp_px = pixel_q.pop_front();
        if (out_data_o !== exp_px) begin
          mismatches++;
          if (mismatches <= 10)
            $display("coeff exp %h got %h, rgb exp %h_%h_%h got %h_%h_%h",
                     exp_px.noise_coeff, out_data_o.noise_coeff, exp_px.red,
                     exp_px.green, exp_px.blue, out_data_o.red, out_data_o.green,
                     out_data_o.blue);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    oct_count = 4'd4;
    persist = 16'd32768;
    scale = 10'd100;
    color_a = 24'd6697932;
    color_b = 24'd1749837;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_octaves();
    test_random();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
